// File: hdl/tsbb_pkg.sv
// Shared types and constants of the one-second trade bar builder.
// Used by the channel interfaces and by every module of the block; no dependencies.
`default_nettype none

package tsbb_pkg;

    // Field widths of the input and result items.
    localparam int TIME_W  = 44;
    localparam int SEC_W   = 35;
    localparam int PX_W    = 32;
    localparam int QTY_W   = 32;
    localparam int VOL_W   = 48;
    localparam int CNT_W   = 32;
    localparam int DELTA_W = 48;
    localparam int GAP_W   = 16;

    // Request codes.
    localparam logic REQ_TRADE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Millisecond to second conversion: t / 1000 = (t >> 3) / 125, and the
    // division by 125 is a multiply by ceil(2^48 / 125) keeping bits 82:48.
    localparam int              DIV_PRE_SHIFT = 3;
    localparam int              DIV_X_W       = TIME_W - DIV_PRE_SHIFT;
    localparam int              RECIP_W       = 42;
    localparam logic [RECIP_W-1:0] RECIP_125  = 42'h20C49BA5E36;
    localparam int              DIV_Q_LSB     = 48;
    localparam int              PROD_W        = DIV_X_W + RECIP_W;
    localparam int              SPLIT_W       = 21;
    localparam int              PP_W          = 2 * SPLIT_W;
    localparam int              MID_W         = PP_W + 1;
    localparam int              DIV_STAGES    = 4;
    localparam int              STAGE_CNT_W   = 3;

    // Result queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    // One input item as it arrives on the request channel.
    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] trade_time_ms;
        logic [TIME_W-1:0] message_time_ms;
        logic [PX_W-1:0]   price;
        logic [QTY_W-1:0]  quantity;
        logic              buyer_maker;
    } t_req;

    // One closed bar as it leaves on the result channel.
    typedef struct packed {
        logic [SEC_W-1:0]          bar_second;
        logic [PX_W-1:0]           bar_open;
        logic [PX_W-1:0]           bar_high;
        logic [PX_W-1:0]           bar_low;
        logic [PX_W-1:0]           bar_close;
        logic [VOL_W-1:0]          total_volume;
        logic [VOL_W-1:0]          buy_volume;
        logic [VOL_W-1:0]          sell_volume;
        logic [CNT_W-1:0]          trade_count;
        logic signed [DELTA_W-1:0] cumulative_delta;
        logic [GAP_W-1:0]          empty_seconds_after;
    } t_bar;

    // An item after the time fallback has been resolved.
    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] time_ms;
        logic [PX_W-1:0]   price;
        logic [QTY_W-1:0]  quantity;
        logic              buyer_maker;
    } t_work;

    // An item together with its epoch second.
    typedef struct packed {
        t_work            work;
        logic [SEC_W-1:0] sec;
    } t_timed;

endpackage

`default_nettype wire

// File: hdl/tsbb_if.sv
// Valid/ready channel interfaces for trade requests and closed bars.
// Depends on tsbb_pkg for the payload types.
`default_nettype none

interface tsbb_req_if;
    logic             valid;
    logic             ready;
    tsbb_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tsbb_bar_if;
    logic             valid;
    logic             ready;
    tsbb_pkg::t_bar   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/tsbb_sec_div.sv
// Front pipeline: resolves the item time and divides it by 1000 to an epoch second.
// Depends on tsbb_pkg; four register stages, one item per cycle.
`default_nettype none

module tsbb_sec_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  tsbb_pkg::t_req                        i_req,
    output logic                                  o_valid,
    output tsbb_pkg::t_timed                      o_item,
    output logic [tsbb_pkg::DIV_STAGES-1:0]       o_stage_valid
);

    localparam int SW = tsbb_pkg::SPLIT_W;

    // Stage valid bits.
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;

    // Payload carried alongside the arithmetic.
    tsbb_pkg::t_work r_s1_work, r_s2_work, r_s3_work, r_s4_work;
    tsbb_pkg::t_work n_s1_work;

    // Arithmetic registers.
    logic [tsbb_pkg::PP_W-1:0]      r_pp_ll, r_pp_lh;
    logic [tsbb_pkg::PP_W-2:0]      r_pp_hl, r_pp_hh;
    logic [tsbb_pkg::PROD_W-1:0]    r_cat;
    logic [tsbb_pkg::MID_W-1:0]     r_mid;
    logic [tsbb_pkg::SEC_W-1:0]     r_sec;

    logic [tsbb_pkg::DIV_X_W-1:0]   x;
    logic [SW-1:0]                  x_lo, m_lo, m_hi;
    logic [tsbb_pkg::DIV_X_W-SW-1:0] x_hi;
    logic [tsbb_pkg::PROD_W-1:0]    prod;

    // The trade time is used unless it is zero; a tick always uses its own time.
    always_comb begin
        n_s1_work.req_type    = i_req.req_type;
        n_s1_work.price       = i_req.price;
        n_s1_work.quantity    = i_req.quantity;
        n_s1_work.buyer_maker = i_req.buyer_maker;
        if (i_req.req_type == tsbb_pkg::REQ_TICK || i_req.trade_time_ms != '0) begin
            n_s1_work.time_ms = i_req.trade_time_ms;
        end else begin
            n_s1_work.time_ms = i_req.message_time_ms;
        end
    end

    // Split the operands into halves for four narrow partial products.
    assign x    = r_s1_work.time_ms[tsbb_pkg::TIME_W-1:tsbb_pkg::DIV_PRE_SHIFT];
    assign x_lo = x[SW-1:0];
    assign x_hi = x[tsbb_pkg::DIV_X_W-1:SW];
    assign m_lo = tsbb_pkg::RECIP_125[SW-1:0];
    assign m_hi = tsbb_pkg::RECIP_125[tsbb_pkg::RECIP_W-1:SW];

    // The full product; the quotient is its top bits.
    assign prod = r_cat + tsbb_pkg::PROD_W'({r_mid, {SW{1'b0}}});

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    // Data path registers.
    always_ff @(posedge i_clk) begin
        r_s1_work <= n_s1_work;

        r_pp_ll   <= tsbb_pkg::PP_W'(x_lo) * tsbb_pkg::PP_W'(m_lo);
        r_pp_lh   <= tsbb_pkg::PP_W'(x_lo) * tsbb_pkg::PP_W'(m_hi);
        r_pp_hl   <= (tsbb_pkg::PP_W-1)'(x_hi) * (tsbb_pkg::PP_W-1)'(m_lo);
        r_pp_hh   <= (tsbb_pkg::PP_W-1)'(x_hi) * (tsbb_pkg::PP_W-1)'(m_hi);
        r_s2_work <= r_s1_work;

        r_cat     <= {r_pp_hh, r_pp_ll};
        r_mid     <= tsbb_pkg::MID_W'(r_pp_lh) + tsbb_pkg::MID_W'(r_pp_hl);
        r_s3_work <= r_s2_work;

        r_sec     <= prod[tsbb_pkg::PROD_W-1:tsbb_pkg::DIV_Q_LSB];
        r_s4_work <= r_s3_work;
    end

    assign o_valid       = r_s4_valid;
    assign o_item.work   = r_s4_work;
    assign o_item.sec    = r_sec;
    assign o_stage_valid = {r_s4_valid, r_s3_valid, r_s2_valid, r_s1_valid};

endmodule

`default_nettype wire

// File: hdl/tsbb_bar_core.sv
// Bar state: folds trades into the current bar and closes it when a later second begins.
// Depends on tsbb_pkg; the state registers update on each valid item.
`default_nettype none

module tsbb_bar_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  tsbb_pkg::t_timed   i_item,
    output logic               o_res_valid,
    output tsbb_pkg::t_bar     o_res
);

    localparam int VW = tsbb_pkg::VOL_W;
    localparam int DW = tsbb_pkg::DELTA_W;
    localparam int SW = tsbb_pkg::SEC_W;
    localparam int GW = tsbb_pkg::GAP_W;

    // Adds a quantity to a volume, holding at the top of the range.
    function automatic logic [VW-1:0] sat_add_vol(input logic [VW-1:0] a,
                                                  input logic [tsbb_pkg::QTY_W-1:0] b);
        logic [VW:0] s;
        s = {1'b0, a} + (VW+1)'(b);
        return s[VW] ? {VW{1'b1}} : s[VW-1:0];
    endfunction

    // Control state.
    logic                         r_bar_valid;
    logic signed [DW-1:0]         r_prior_delta;
    logic [tsbb_pkg::TIME_W-1:0]  r_last_ms;

    // Current bar.
    logic [SW-1:0]                r_second;
    logic [tsbb_pkg::PX_W-1:0]    r_open, r_high, r_low, r_close;
    logic [VW-1:0]                r_volume, r_buy, r_sell;
    logic [tsbb_pkg::CNT_W-1:0]   r_count;

    logic                         n_bar_valid;
    logic signed [DW-1:0]         n_prior_delta;
    logic [tsbb_pkg::TIME_W-1:0]  n_last_ms;
    logic [SW-1:0]                n_second;
    logic [tsbb_pkg::PX_W-1:0]    n_open, n_high, n_low, n_close;
    logic [VW-1:0]                n_volume, n_buy, n_sell;
    logic [tsbb_pkg::CNT_W-1:0]   n_count;

    tsbb_pkg::t_work              w;
    logic [SW-1:0]                sec;
    logic                         is_tick, sec_nz, tick_go, trade_ok;
    logic                         adv_go, later, open_new, emit;
    logic [tsbb_pkg::PX_W-1:0]    open_px, adv_px;
    logic signed [DW+1:0]         delta_sum;
    logic signed [DW-1:0]         delta_sat;
    logic [SW-1:0]                gap_full;
    logic [GW-1:0]                gap;

    // Running delta through the current bar, held to the signed 48-bit range.
    always_comb begin
        delta_sum = {{2{r_prior_delta[DW-1]}}, r_prior_delta}
                  + $signed({2'b00, r_buy}) - $signed({2'b00, r_sell});
        if (delta_sum[DW+1:DW-1] == 3'b000 || delta_sum[DW+1:DW-1] == 3'b111) begin
            delta_sat = delta_sum[DW-1:0];
        end else if (!delta_sum[DW+1]) begin
            delta_sat = {1'b0, {(DW-1){1'b1}}};
        end else begin
            delta_sat = {1'b1, {(DW-1){1'b0}}};
        end
    end

    // Number of empty seconds between the closing bar and the new one.
    always_comb begin
        gap_full = sec - r_second - SW'(1);
        gap      = (|gap_full[SW-1:GW]) ? {GW{1'b1}} : gap_full[GW-1:0];
    end

    // Classify the item and work out whether the bar moves on.
    always_comb begin
        w        = i_item.work;
        sec      = i_item.sec;
        is_tick  = (w.req_type == tsbb_pkg::REQ_TICK);
        sec_nz   = (sec != '0);
        open_px  = r_bar_valid ? r_close : w.price;
        tick_go  = is_tick && sec_nz && (open_px != '0);
        trade_ok = !is_tick && (w.price != '0) && (w.quantity != '0)
                 && (w.time_ms != '0) && (w.time_ms >= r_last_ms);
        adv_go   = i_valid && (tick_go || (trade_ok && sec_nz));
        later    = (r_second < sec);
        open_new = adv_go && (!r_bar_valid || later);
        emit     = adv_go && r_bar_valid && later;
        adv_px   = is_tick ? open_px : w.price;
    end

    // Next state: open a new bar if needed, then apply an accepted trade.
    always_comb begin
        n_last_ms     = r_last_ms;
        n_prior_delta = emit ? delta_sat : r_prior_delta;
        n_bar_valid   = r_bar_valid || open_new;
        if (open_new) begin
            n_second = sec;
            n_open   = adv_px;
            n_high   = adv_px;
            n_low    = adv_px;
            n_close  = adv_px;
            n_volume = '0;
            n_buy    = '0;
            n_sell   = '0;
            n_count  = '0;
        end else begin
            n_second = r_second;
            n_open   = r_open;
            n_high   = r_high;
            n_low    = r_low;
            n_close  = r_close;
            n_volume = r_volume;
            n_buy    = r_buy;
            n_sell   = r_sell;
            n_count  = r_count;
        end
        if (i_valid && trade_ok) begin
            n_last_ms = w.time_ms;
            if (n_bar_valid) begin
                if (w.price > n_high) begin
                    n_high = w.price;
                end
                if (w.price < n_low) begin
                    n_low = w.price;
                end
                n_close  = w.price;
                n_volume = sat_add_vol(n_volume, w.quantity);
                if (w.buyer_maker) begin
                    n_sell = sat_add_vol(n_sell, w.quantity);
                end else begin
                    n_buy = sat_add_vol(n_buy, w.quantity);
                end
                if (!(&n_count)) begin
                    n_count = n_count + tsbb_pkg::CNT_W'(1);
                end
            end
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_valid   <= 1'b0;
            r_prior_delta <= '0;
            r_last_ms     <= '0;
        end else if (i_valid) begin
            r_bar_valid   <= n_bar_valid;
            r_prior_delta <= n_prior_delta;
            r_last_ms     <= n_last_ms;
        end
    end

    // Bar contents; only read while a bar is open.
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_second <= n_second;
            r_open   <= n_open;
            r_high   <= n_high;
            r_low    <= n_low;
            r_close  <= n_close;
            r_volume <= n_volume;
            r_buy    <= n_buy;
            r_sell   <= n_sell;
            r_count  <= n_count;
        end
    end

    // The closing bar is the bar held before this item.
    assign o_res_valid                 = emit;
    assign o_res.bar_second            = r_second;
    assign o_res.bar_open              = r_open;
    assign o_res.bar_high              = r_high;
    assign o_res.bar_low               = r_low;
    assign o_res.bar_close             = r_close;
    assign o_res.total_volume          = r_volume;
    assign o_res.buy_volume            = r_buy;
    assign o_res.sell_volume           = r_sell;
    assign o_res.trade_count           = r_count;
    assign o_res.cumulative_delta      = delta_sat;
    assign o_res.empty_seconds_after   = gap;

    // A bar only closes when one is open and a strictly later second arrives.
    a_close_needs_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_bar_valid && (r_second < i_item.sec)))
        else $error("bar closed without an open bar or a later second");

    // After a close the new bar is open at the item's second.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_bar_valid && (r_second == $past(i_item.sec))))
        else $error("new bar not opened after a close");

    // The last accepted trade time never goes backwards.
    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_last_ms >= $past(r_last_ms)))
        else $error("last accepted trade time decreased");

endmodule

`default_nettype wire

// File: hdl/tsbb_out_fifo.sv
// Result queue between the bar state and the result channel.
// Depends on tsbb_pkg and tsbb_bar_if; reports its fill level for flow control.
`default_nettype none

module tsbb_out_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_valid,
    input  tsbb_pkg::t_bar                      i_wr_data,
    output logic [tsbb_pkg::FIFO_CNT_W-1:0]     o_count,
    tsbb_bar_if.source                          o_bar
);

    localparam int PW = tsbb_pkg::FIFO_PTR_W;
    localparam int CW = tsbb_pkg::FIFO_CNT_W;

    tsbb_pkg::t_bar  r_entry [tsbb_pkg::FIFO_DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            rd;

    assign rd = o_bar.valid && o_bar.ready;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_valid) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(i_wr_valid) - CW'(rd);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_wr_valid) begin
            r_entry[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_bar.valid = (r_count != '0);
    assign o_bar.data  = r_entry[r_rd_ptr];
    assign o_count     = r_count;

    // Flow control upstream must keep the queue from overflowing.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid |-> (r_count < CW'(tsbb_pkg::FIFO_DEPTH)))
        else $error("result queue written while full");

    // A write without a read raises the fill level by one.
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_valid && !rd) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("result queue level out of step");

endmodule

`default_nettype wire

// File: hdl/trade_to_second_bar_builder.sv
// Top level of the one-second OHLCV bar builder: time divider, bar state and result queue.
// Depends on tsbb_pkg, tsbb_if, tsbb_sec_div, tsbb_bar_core and tsbb_out_fifo.
//
// Use: trades and clock ticks arrive as items on i_req (valid/ready); each
// closed bar leaves as one item on o_bar (valid/ready), carrying its second,
// OHLC prices, volumes, trade count, running delta and the count of empty
// seconds that follow it. Items that close no bar give no result.
// Path: an accepted item passes the register stages of the millisecond-to-second
// divide, a multiply by a reciprocal split into partial products, and is then
// folded into the bar; a bar it closes is written to the result queue, which
// offers it on o_bar.
// Throughput: one item per cycle while i_req.ready is high. The bar state takes
// an item every cycle, and an eight-entry result queue holds closed bars while
// the receiver stalls. Outside reset, i_req.ready drops only when the queued
// bars plus items still in the divide pipeline reach eight, so results are never lost.
// Reset (synchronous, active low) empties the pipeline and queue, clears the
// open bar, the running delta and the last accepted trade time. No item is
// accepted during reset.
`default_nettype none

module trade_to_second_bar_builder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsbb_req_if.sink      i_req,
    tsbb_bar_if.source    o_bar
);

    localparam int CW = tsbb_pkg::FIFO_CNT_W;

    logic                               accept;
    logic                               div_valid;
    tsbb_pkg::t_timed                   div_item;
    logic [tsbb_pkg::DIV_STAGES-1:0]    stage_valid;
    logic [tsbb_pkg::STAGE_CNT_W-1:0]   inflight;
    logic [CW:0]                        credit_used;
    logic [CW-1:0]                      fifo_count;
    logic                               res_valid;
    tsbb_pkg::t_bar                     res;

    // Items in flight plus queued bars must leave room for every possible result.
    assign inflight     = tsbb_pkg::STAGE_CNT_W'($countones(stage_valid));
    assign credit_used  = {1'b0, fifo_count} + (CW+1)'(inflight);
    assign i_req.ready  = i_rst_n && (credit_used < (CW+1)'(tsbb_pkg::FIFO_DEPTH));
    assign accept       = i_req.valid && i_req.ready;

    tsbb_sec_div u_sec_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_req          (i_req.data),
        .o_valid        (div_valid),
        .o_item         (div_item),
        .o_stage_valid  (stage_valid)
    );

    tsbb_bar_core u_bar_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (div_valid),
        .i_item         (div_item),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    tsbb_out_fifo u_out_fifo (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_valid     (res_valid),
        .i_wr_data      (res),
        .o_count        (fifo_count),
        .o_bar          (o_bar)
    );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench of the one-second trade bar builder.
// Depends on tsbb_pkg, tsbb_if and trade_to_second_bar_builder in hdl.
// A bar tracker predicts every closed bar and compares it field by field.

// Tracks the bar being built and queues the bars that it expects to close.
class bar_tracker;
    localparam bit [tsbb_pkg::TIME_W-1:0] MS_PER_SEC = 1000;
    localparam bit [tsbb_pkg::GAP_W-1:0]  GAP_TOP    = '1;
    localparam longint          DELTA_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint          DELTA_LO   = -DELTA_HI - 1;

    bit                                 have_bar;
    bit [tsbb_pkg::SEC_W-1:0]           cur_sec;
    bit [tsbb_pkg::PX_W-1:0]            px_first;
    bit [tsbb_pkg::PX_W-1:0]            px_top;
    bit [tsbb_pkg::PX_W-1:0]            px_bottom;
    bit [tsbb_pkg::PX_W-1:0]            px_last;
    bit [tsbb_pkg::VOL_W-1:0]           vol_all;
    bit [tsbb_pkg::VOL_W-1:0]           vol_buy;
    bit [tsbb_pkg::VOL_W-1:0]           vol_sell;
    bit [tsbb_pkg::CNT_W-1:0]           n_trades;
    bit signed [tsbb_pkg::DELTA_W-1:0]  delta_before;
    bit [tsbb_pkg::TIME_W-1:0]          newest_ms;
    tsbb_pkg::t_bar                     owed_bars[$];
    int unsigned                        failures;

    // Delta through the current bar, clamped to the signed 48-bit range.
    function bit signed [tsbb_pkg::DELTA_W-1:0] running_delta();
        longint sum;
        sum = longint'(delta_before) + longint'(vol_buy) - longint'(vol_sell);
        if (sum > DELTA_HI) sum = DELTA_HI;
        if (sum < DELTA_LO) sum = DELTA_LO;
        return sum[tsbb_pkg::DELTA_W-1:0];
    endfunction

    function bit [tsbb_pkg::VOL_W-1:0] sat_sum(bit [tsbb_pkg::VOL_W-1:0] acc,
                                               bit [tsbb_pkg::QTY_W-1:0] qty);
        bit [tsbb_pkg::VOL_W:0] s;
        s = acc + qty;
        return s[tsbb_pkg::VOL_W] ? '1 : s[tsbb_pkg::VOL_W-1:0];
    endfunction

    // Moves the bar on to a later second, closing the old one if there is one.
    function void roll_to(bit [tsbb_pkg::SEC_W-1:0] sec, bit [tsbb_pkg::PX_W-1:0] px);
        tsbb_pkg::t_bar           done;
        bit [tsbb_pkg::SEC_W-1:0] span;
        if (have_bar) begin
            if (cur_sec >= sec) return;
            span = sec - cur_sec - 1;
            done.bar_second          = cur_sec;
            done.bar_open            = px_first;
            done.bar_high            = px_top;
            done.bar_low             = px_bottom;
            done.bar_close           = px_last;
            done.total_volume        = vol_all;
            done.buy_volume          = vol_buy;
            done.sell_volume         = vol_sell;
            done.trade_count         = n_trades;
            done.cumulative_delta    = running_delta();
            done.empty_seconds_after = (span > GAP_TOP) ? GAP_TOP
                                                        : span[tsbb_pkg::GAP_W-1:0];
            owed_bars.insert(owed_bars.size(), done);
            delta_before = done.cumulative_delta;
        end
        have_bar  = 1'b1;
        cur_sec   = sec;
        px_first  = px;
        px_top    = px;
        px_bottom = px;
        px_last   = px;
        vol_all   = '0;
        vol_buy   = '0;
        vol_sell  = '0;
        n_trades  = '0;
    endfunction

    // Folds one accepted item into the bar.
    function void note_item(tsbb_pkg::t_req item);
        bit [tsbb_pkg::TIME_W-1:0] stamp;
        bit [tsbb_pkg::TIME_W-1:0] whole_sec;
        bit [tsbb_pkg::PX_W-1:0]   start_px;
        if (item.req_type == tsbb_pkg::REQ_TICK) begin
            start_px  = have_bar ? px_last : item.price;
            whole_sec = item.trade_time_ms / MS_PER_SEC;
            if (item.trade_time_ms != '0 && whole_sec != '0 && start_px != '0)
                roll_to(whole_sec[tsbb_pkg::SEC_W-1:0], start_px);
            return;
        end
        if (item.price == '0 || item.quantity == '0) return;
        stamp = (item.trade_time_ms != '0) ? item.trade_time_ms : item.message_time_ms;
        if (stamp == '0 || stamp < newest_ms) return;
        newest_ms = stamp;
        whole_sec = stamp / MS_PER_SEC;
        if (whole_sec != '0) roll_to(whole_sec[tsbb_pkg::SEC_W-1:0], item.price);
        // A trade in second zero with no bar open is lost.
        if (!have_bar) return;
        if (item.price > px_top)    px_top = item.price;
        if (item.price < px_bottom) px_bottom = item.price;
        px_last = item.price;
        vol_all = sat_sum(vol_all, item.quantity);
        if (item.buyer_maker) vol_sell = sat_sum(vol_sell, item.quantity);
        else                  vol_buy  = sat_sum(vol_buy, item.quantity);
        if (n_trades != '1) n_trades++;
    endfunction

    function void field_check(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // Compares a bar from the block with the oldest one expected.
    function void check_bar(tsbb_pkg::t_bar got);
        tsbb_pkg::t_bar want;
        if (owed_bars.size() == 0) begin
            $error("bar for second %0d arrived with none expected", got.bar_second);
            failures++;
            return;
        end
        want = owed_bars[0];
        owed_bars.delete(0);
        field_check("bar_second", want.bar_second, got.bar_second);
        field_check("bar_open", want.bar_open, got.bar_open);
        field_check("bar_high", want.bar_high, got.bar_high);
        field_check("bar_low", want.bar_low, got.bar_low);
        field_check("bar_close", want.bar_close, got.bar_close);
        field_check("total_volume", want.total_volume, got.total_volume);
        field_check("buy_volume", want.buy_volume, got.buy_volume);
        field_check("sell_volume", want.sell_volume, got.sell_volume);
        field_check("trade_count", want.trade_count, got.trade_count);
        field_check("cumulative_delta", want.cumulative_delta, got.cumulative_delta);
        field_check("empty_seconds_after", want.empty_seconds_after,
                    got.empty_seconds_after);
    endfunction
endclass

module tb_top;
    localparam int          RANDOM_ITEMS   = 1825;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam bit [tsbb_pkg::TIME_W-1:0] TIME_TOP = '1;

    logic       i_clk;
    logic       i_rst_n;
    bit         steady;
    int         idle_cycles;
    bar_tracker ledger;

    tsbb_req_if req_ch ();
    tsbb_bar_if bar_ch ();

    trade_to_second_bar_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_bar   (bar_ch)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic bit [tsbb_pkg::TIME_W-1:0] any_time();
        bit [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[tsbb_pkg::TIME_W-1:0];
    endfunction

    function automatic bit [31:0] nonzero32();
        return ($urandom % 32'hFFFF_FFFF) + 32'd1;
    endfunction

    function automatic tsbb_pkg::t_req trade_item(bit [tsbb_pkg::TIME_W-1:0] tt,
                                                  bit [tsbb_pkg::TIME_W-1:0] mt,
                                                  bit [tsbb_pkg::PX_W-1:0] px,
                                                  bit [tsbb_pkg::QTY_W-1:0] qty,
                                                  bit seller);
        tsbb_pkg::t_req r;
        r.req_type        = tsbb_pkg::REQ_TRADE;
        r.trade_time_ms   = tt;
        r.message_time_ms = mt;
        r.price           = px;
        r.quantity        = qty;
        r.buyer_maker     = seller;
        return r;
    endfunction

    // Quantity, fallback time and side are ignored on a tick, so they are random.
    function automatic tsbb_pkg::t_req tick_item(bit [tsbb_pkg::TIME_W-1:0] tt,
                                                 bit [tsbb_pkg::PX_W-1:0] px);
        tsbb_pkg::t_req r;
        r.req_type        = tsbb_pkg::REQ_TICK;
        r.trade_time_ms   = tt;
        r.message_time_ms = any_time();
        r.price           = px;
        r.quantity        = $urandom;
        r.buyer_maker     = $urandom_range(0, 1);
        return r;
    endfunction

    // Offers one item after a random gap, unless steady is set, and waits until the block takes it.
    task automatic send_item(tsbb_pkg::t_req item);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.data  <= item;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        ledger.note_item(item);
    endtask

    // Result side: stalls at random unless steady is set, then takes and checks one bar.
    initial begin : bar_sink
        int stall;
        bar_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                bar_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            bar_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(bar_ch.valid && bar_ch.ready));
            ledger.check_bar(bar_ch.data);
        end
    end

    // Ends the run when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (bar_ch.valid && bar_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("trade_to_second_bar_builder: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        tsbb_pkg::t_req            plan[$];
        tsbb_pkg::t_req            item;
        bit [tsbb_pkg::TIME_W-1:0] clock_ms;
        bit [tsbb_pkg::PX_W-1:0]   px_base;
        bit [tsbb_pkg::PX_W-1:0]   px;
        bit [tsbb_pkg::QTY_W-1:0]  qty;
        bit [63:0]                 jump;
        int                        pick;
        int                        step;

        ledger       = new();
        steady       = 1'b0;
        idle_cycles  = 0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: drops, second zero, fallback time, ticks and gap saturation.
        plan = {plan, trade_item(500, 0, 100, 10, 0)};       // second zero, no bar: lost
        plan = {plan, tick_item(0, 200)};                    // tick with zero time
        plan = {plan, tick_item(999, 200)};                  // tick in second zero
        plan = {plan, tick_item(5000, 0)};                   // no bar and zero price
        plan = {plan, tick_item(5000, 100)};                 // tick opens the first bar
        plan = {plan, trade_item(700, 0, 90, 5, 1)};         // second zero joins the bar
        plan = {plan, trade_item(6000, 0, 0, 5, 0)};         // zero price
        plan = {plan, trade_item(6000, 0, 95, 0, 0)};        // zero quantity
        plan = {plan, trade_item(0, 0, 95, 5, 0)};           // zero time after fallback
        plan = {plan, trade_item(0, 6000, 110, 7, 0)};       // message time used
        plan = {plan, trade_item(5500, 0, 120, 3, 0)};       // older than last trade
        plan = {plan, trade_item(6100, 99999, 130, 4, 1)};   // same second
        plan = {plan, tick_item(8000, 0)};                   // tick closes with a gap
        plan = {plan, trade_item(7500, 0, 125, 2, 0)};       // earlier second than bar
        plan = {plan, tick_item(8900, 77)};                  // tick in the bar's second
        plan = {plan, trade_item(9000, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0)};
        plan = {plan, trade_item(9001, 0, 1, 32'hFFFF_FFFF, 1)};
        plan = {plan, trade_item(70009001, 0, 500, 1, 0)};   // gap beyond the top
        plan = {plan, trade_item(135545000, 0, 501, 1, 1)};  // gap exactly at the top
        plan = {plan, trade_item(201080000, 0, 502, 1, 0)};  // gap just below the top
        plan = {plan, tick_item(201082000, 0)};
        plan = {plan, trade_item(201080000, 0, 503, 2, 1)};  // equal to the last time
        foreach (plan[i]) send_item(plan[i]);

        // Random: mostly well-formed trades and ticks on a rising clock, some noise.
        jump     = {$urandom, $urandom};
        clock_ms = 303000000 + jump[39:0];
        px_base  = $urandom_range(1000, 1000000);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 49) == 0) steady = ~steady;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                step = $urandom_range(0, 99);
                if (step < 55)      clock_ms += $urandom_range(0, 400);
                else if (step < 85) clock_ms += $urandom_range(600, 3500);
                else if (step < 97) clock_ms += $urandom_range(3500, 60000);
                else                clock_ms += $urandom_range(65535000, 70000000);
                px_base = px_base + $urandom_range(0, 20) - 10;
                if (px_base == '0) px_base = 1;
                px  = ($urandom_range(0, 99) < 15) ? nonzero32()
                                                   : px_base + $urandom_range(0, 50);
                if (px == '0) px = 1;
                qty = ($urandom_range(0, 4) == 0) ? nonzero32() : $urandom_range(1, 1000);
                if ($urandom_range(0, 9) == 0)
                    item = trade_item('0, clock_ms, px, qty, $urandom_range(0, 1));
                else
                    item = trade_item(clock_ms, any_time(), px, qty, $urandom_range(0, 1));
            end else if (pick < 80) begin
                clock_ms += $urandom_range(0, 4000);
                item = tick_item(clock_ms, ($urandom_range(0, 9) == 0) ? '0 : px_base);
            end else begin
                case ($urandom_range(0, 4))
                    0: item = trade_item(any_time(), any_time(), '0, $urandom, 0);
                    1: item = trade_item(any_time(), any_time(), $urandom, '0, 1);
                    2: item = trade_item(clock_ms - $urandom_range(1, 5000), any_time(),
                                         nonzero32(), nonzero32(), $urandom_range(0, 1));
                    3: item = trade_item('0, '0, nonzero32(), nonzero32(), 0);
                    default: item = tick_item($urandom_range(0, 999), $urandom);
                endcase
            end
            send_item(item);
        end

        // The top of the time range last, since nothing may follow it.
        steady = 1'b0;
        send_item(trade_item(TIME_TOP - 1000, 0, 42, 3, 0));
        send_item(trade_item(TIME_TOP, 0, 43, 4, 1));
        send_item(tick_item(TIME_TOP, 44));
        req_ch.valid <= 1'b0;

        while (ledger.owed_bars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.failures == 0) begin
            $display("trade_to_second_bar_builder: match");
        end else begin
            $display("trade_to_second_bar_builder: mismatch");
        end
        $finish;
    end
endmodule
